// File: design/oad_pkg.sv
package oad_pkg;

    // Request codes as they arrive on the input channel.
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // Classified request kinds carried through the queue.
    typedef enum logic [1:0] {
        K_APPEND,
        K_DELETE,
        K_LIST
    } t_kind;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_LISTED    = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LIST
    } t_state;

endpackage

// File: design/ordered_list_append_delete.sv
// Ordered list of signed 32-bit values holding up to CAPACITY entries. Each
// request appends a value at the tail, deletes the first entry from the head
// that equals a value, or lists every entry from head to tail; action code 3
// is accepted and produces no result. Every other request produces results
// whose final one carries o_last. A short request queue separates the input
// side from the list engine, so new requests are taken while the engine works
// or while a result waits on a stalled output. An append is done in the cycle
// that takes it. A delete first compares all cells in parallel and then
// closes up the cells behind the first match. A list takes the request and
// then walks the list, presenting the head cell and rotating the valid cells
// by one place for each entry it presents. A delete or a list on an empty
// list answers in the cycle that takes it. A list of a full list of CAPACITY
// entries holds the engine longest of any request, and a stalled output holds
// it further. After reset the list is empty and ready at once.
module ordered_list_append_delete #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic               o_last
);
    import oad_pkg::*;

    // Request queue handoff between the front and the list engine.
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_pop;

    oad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_pop)
    );

    // The engine owns the entry cells, the count and the output register.
    oad_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

endmodule

// File: design/oad_front.sv
module oad_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    output logic               o_cmd_valid,
    output oad_pkg::t_cmd      o_cmd,
    input  logic               i_pop
);
    import oad_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       w_accept;
    logic       w_push;
    t_cmd       w_cmd;

    // The unused action code is accepted and dropped here.
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.kind  = K_APPEND;
        w_push      = 1'b0;
        unique case (i_action)
            ACT_APPEND: begin
                w_cmd.kind = K_APPEND;
                w_push     = w_accept;
            end
            ACT_DELETE: begin
                w_cmd.kind = K_DELETE;
                w_push     = w_accept;
            end
            ACT_LIST: begin
                w_cmd.kind = K_LIST;
                w_push     = w_accept;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = (r_fill == 2'd2);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_fill = r_fill;
        if (w_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!w_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("queue fill out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_fill != 2'd0)
        else $error("pop from empty queue");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_fill == $past(r_fill) || r_fill == $past(r_fill) + 2'd1
             || r_fill == $past(r_fill) - 2'd1))
        else $error("queue fill jumped");

endmodule

// File: design/oad_back.sv
module oad_back #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  oad_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic               o_last
);
    import oad_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    t_state             r_state;
    t_state             n_state;
    logic signed [31:0] r_cells [CAPACITY];
    logic signed [31:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CAPACITY-1:0] r_hit;
    logic [CAPACITY-1:0] n_hit;
    logic [CAPACITY-1:0] w_mask;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               w_out_free;
    logic               w_list_last;
    logic               w_emit;
    t_status            w_status;
    logic signed [31:0] w_value;
    logic               w_last;
    logic               r_out_valid;
    t_status            r_status;
    logic signed [31:0] r_value;
    logic               r_last;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_list_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // Cells at and behind the first match take their neighbor's value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_mask[i] = (r_hit << (CAPACITY - 1 - i)) != '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free && r_count != '0) begin
                    if (i_cmd.kind == K_DELETE) begin
                        n_state = S_SHIFT;
                    end else if (i_cmd.kind == K_LIST) begin
                        n_state = S_LIST;
                    end
                end
            end
            S_SHIFT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (w_out_free && w_list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_emit   = 1'b0;
        w_status = ST_APPENDED;
        w_value  = '0;
        w_last   = 1'b1;
        n_count  = r_count;
        n_hit    = r_hit;
        n_idx    = r_idx;
        n_cells  = r_cells;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        K_APPEND: begin
                            w_emit = 1'b1;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_status = ST_APPENDED;
                                n_count  = r_count + CNT_W'(1);
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (CNT_W'(i) == r_count) begin
                                        n_cells[i] = i_cmd.value;
                                    end
                                end
                            end
                        end
                        K_DELETE: begin
                            if (r_count == '0) begin
                                w_emit   = 1'b1;
                                w_status = ST_EMPTY;
                            end
                            for (int i = 0; i < CAPACITY; i++) begin
                                n_hit[i] = (CNT_W'(i) < r_count)
                                           && (r_cells[i] == i_cmd.value);
                            end
                        end
                        K_LIST: begin
                            if (r_count == '0) begin
                                w_emit   = 1'b1;
                                w_status = ST_EMPTY;
                            end
                            n_idx = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_hit == '0) begin
                        w_status = ST_NOT_FOUND;
                    end else begin
                        w_status = ST_DELETED;
                        n_count  = r_count - CNT_W'(1);
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (w_mask[i]) begin
                                n_cells[i] = r_cells[i + 1];
                            end
                        end
                    end
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    // Emit the head and rotate the valid cells by one place,
                    // so the whole list is back in order after the walk.
                    w_emit   = 1'b1;
                    w_status = ST_LISTED;
                    w_value  = r_cells[0];
                    w_last   = w_list_last;
                    n_idx    = r_idx + IDX_W'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CNT_W'(i + 1) < r_count) begin
                            n_cells[i] = r_cells[(i + 1) % CAPACITY];
                        end else if (CNT_W'(i + 1) == r_count) begin
                            n_cells[i] = r_cells[0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        r_hit   <= n_hit;
        r_idx   <= n_idx;
        if (w_emit) begin
            r_status <= w_status;
            r_value  <= w_value;
            r_last   <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_last        = r_last;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_list_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIST |-> CNT_W'(r_idx) < r_count)
        else $error("list walk past tail");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1)
             || r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count jumped");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE && i_cmd_valid)
        else $error("request taken while busy");

endmodule
